@@ hdl/table_driven_dfa_matcher_defines.svh @@
// Assertion macros used by the DFA matcher back end (tddm_back).
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef TABLE_DRIVEN_DFA_MATCHER_DEFINES_SVH
`define TABLE_DRIVEN_DFA_MATCHER_DEFINES_SVH

// Same-cycle implication.
`define DFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tddm_pkg.sv @@
// Shared types and constants of the table-driven DFA matcher.
// No dependencies; the matcher modules refer to it by scoped names.
package tddm_pkg;

	localparam int CHAR_W = 8;
	localparam int SYM_W = 4;
	localparam int STATE_W = 6;
	localparam int MAP_DEPTH = 256;

	localparam logic [1:0] OP_MAP = 2'd0;
	localparam logic [1:0] OP_TRANS = 2'd1;
	localparam logic [1:0] OP_ACCEPT = 2'd2;
	localparam logic [1:0] OP_FEED = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 1'd1;
	localparam logic [STATE_W-1:0] HIGHEST_RESET = 6'd63;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW = 2;

	typedef struct packed {
		logic is_map;
		logic is_trans;
		logic is_accept;
		logic is_char;
		logic is_term;
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic [CHAR_W-1:0] char_code;
		logic [SYM_W-1:0] symbol_index;
		logic [STATE_W-1:0] from_state;
		logic [STATE_W-1:0] to_state;
		logic flag;
	} item_t;

	typedef struct packed {
		logic valid;
		logic [SYM_W-1:0] symbol;
	} map_entry_t;

	typedef struct packed {
		logic valid;
		logic [STATE_W-1:0] dest;
	} trans_entry_t;

endpackage

@@ hdl/tddm_front.sv @@
// Front end of the DFA matcher: input handshake and item classification.
// Depends on tddm_pkg.
module tddm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	input  logic [tddm_pkg::CHAR_W-1:0] char_code,
	input  logic [tddm_pkg::SYM_W-1:0] symbol_index,
	input  logic [tddm_pkg::STATE_W-1:0] from_state,
	input  logic [tddm_pkg::STATE_W-1:0] to_state,
	input  logic flag,
	input  logic busy,
	input  logic q_ready,
	output logic push,
	output tddm_pkg::item_t push_item
);

	logic f_v_q;
	tddm_pkg::item_t f_item_q;
	tddm_pkg::cls_t cls;
	logic is_end;

	assign is_end = (char_code == tddm_pkg::CHAR_NUL) || (char_code == tddm_pkg::CHAR_NL);

	always_comb begin
		cls = '0;
		unique case (op)
			tddm_pkg::OP_MAP: cls.is_map = 1'b1;
			tddm_pkg::OP_TRANS: cls.is_trans = 1'b1;
			tddm_pkg::OP_ACCEPT: cls.is_accept = 1'b1;
			tddm_pkg::OP_FEED: begin
				cls.is_term = is_end;
				cls.is_char = !is_end;
			end
		endcase
	end

	assign in_ready = !busy && (!f_v_q || q_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			f_v_q <= 1'b1;
		end else if (q_ready) begin
			f_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_item_q <= '{cls: cls, char_code: char_code, symbol_index: symbol_index,
				from_state: from_state, to_state: to_state, flag: flag};
		end
	end

	assign push = f_v_q;
	assign push_item = f_item_q;

endmodule

@@ hdl/tddm_queue.sv @@
// Short queue of classified items between the front and back of the DFA matcher.
// Depends on tddm_pkg.
module tddm_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tddm_pkg::item_t push_item,
	output logic ready,
	output logic valid,
	output tddm_pkg::item_t item,
	input  logic pop
);

	tddm_pkg::item_t slots_q [tddm_pkg::QUEUE_DEPTH];
	logic [tddm_pkg::QUEUE_AW-1:0] wptr_q;
	logic [tddm_pkg::QUEUE_AW-1:0] rptr_q;
	logic [tddm_pkg::QUEUE_AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign ready = cnt_q != (tddm_pkg::QUEUE_AW + 1)'(tddm_pkg::QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign item = slots_q[rptr_q];
	assign do_push = push && ready;
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= push_item;
		end
	end

endmodule

@@ hdl/tddm_back.sv @@
// Back end of the DFA matcher: table memories, run state, verdicts and output queue.
// Depends on tddm_pkg and table_driven_dfa_matcher_defines.svh.
`include "table_driven_dfa_matcher_defines.svh"

module tddm_back #(
	parameter int MAX_STATES = 64,
	parameter int ALPHABET_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  tddm_pkg::item_t q_item,
	output logic q_pop,
	input  logic [tddm_pkg::STATE_W-1:0] start_state,
	input  logic [tddm_pkg::STATE_W-1:0] highest_state,
	output logic busy,
	output logic out_valid,
	input  logic out_ready,
	output logic accepted
);

	localparam int STW = $clog2(MAX_STATES);
	localparam int SYW = $clog2(ALPHABET_SIZE);
	localparam int TAW = STW + SYW;
	localparam int TDEPTH = 2 ** TAW;
	localparam int ADEPTH = 2 ** STW;
	localparam int CLR_LEN = (TDEPTH > tddm_pkg::MAP_DEPTH) ? TDEPTH : tddm_pkg::MAP_DEPTH;
	localparam int CW = $clog2(CLR_LEN);

	tddm_pkg::map_entry_t map_mem [tddm_pkg::MAP_DEPTH];
	tddm_pkg::trans_entry_t trans_mem [TDEPTH];
	logic acc_mem [ADEPTH];

	logic clr_q;
	logic [CW-1:0] clr_cnt_q;

	logic s1_v_q;
	tddm_pkg::item_t s1_item_q;
	tddm_pkg::map_entry_t map_rd_q;
	tddm_pkg::trans_entry_t trd_q;

	logic started_q;
	logic dead_q;
	logic pend_q;
	logic [tddm_pkg::STATE_W-1:0] cur_q;

	logic s2_v_q;
	logic s2_live_q;
	logic acc_rd_q;

	logic ofifo_q [tddm_pkg::OUT_DEPTH];
	logic [tddm_pkg::OUT_AW-1:0] owptr_q;
	logic [tddm_pkg::OUT_AW-1:0] orptr_q;
	logic [tddm_pkg::OUT_AW:0] ocnt_q;

	logic credit_ok;
	logic s1_go;
	logic pop;
	logic from_ok;
	logic to_ok;
	logic sym_ok;
	logic map_we;
	logic [tddm_pkg::CHAR_W-1:0] map_wa;
	tddm_pkg::map_entry_t map_wd;
	logic [tddm_pkg::STATE_W-1:0] live_state;
	logic live_dead;
	logic [tddm_pkg::STATE_W-1:0] run_state;
	logic run_dead;
	logic state_in_range;
	logic [TAW-1:0] t_raddr;
	logic [TAW-1:0] t_waddr;
	logic trd_re;
	logic tw;
	logic aw;
	logic term_go;
	logic opush;
	logic opop;

	// Run state seen by the item in s1, with a pending transition read folded in.
	assign live_state = pend_q ? trd_q.dest : cur_q;
	assign live_dead = dead_q || (pend_q && !trd_q.valid);
	assign run_state = started_q ? live_state : start_state;
	assign run_dead = started_q && live_dead;
	assign state_in_range = 32'(run_state) < MAX_STATES;

	assign credit_ok = (32'(ocnt_q) + 32'(s2_v_q)) < tddm_pkg::OUT_DEPTH;
	assign s1_go = s1_v_q && (!s1_item_q.cls.is_term || credit_ok);
	assign pop = q_valid && !clr_q && (!s1_v_q || s1_go);
	assign q_pop = pop;
	assign busy = clr_q;

	assign from_ok = (s1_item_q.from_state <= highest_state) &&
		(32'(s1_item_q.from_state) < MAX_STATES);
	assign to_ok = (s1_item_q.to_state <= highest_state) &&
		(32'(s1_item_q.to_state) < MAX_STATES);
	assign sym_ok = 32'(s1_item_q.symbol_index) < ALPHABET_SIZE;

	assign map_we = clr_q || (s1_go && s1_item_q.cls.is_map && (!s1_item_q.flag || sym_ok));
	assign map_wa = clr_q ? clr_cnt_q[tddm_pkg::CHAR_W-1:0] : s1_item_q.char_code;
	assign map_wd = clr_q ? '0 :
		tddm_pkg::map_entry_t'{valid: s1_item_q.flag, symbol: s1_item_q.symbol_index};

	assign t_raddr = {STW'(run_state), SYW'(map_rd_q.symbol)};
	assign t_waddr = {STW'(s1_item_q.from_state), SYW'(map_rd_q.symbol)};
	assign trd_re = s1_go && s1_item_q.cls.is_char && !run_dead && map_rd_q.valid &&
		state_in_range;
	assign tw = s1_go && s1_item_q.cls.is_trans && from_ok && to_ok && map_rd_q.valid;
	assign aw = s1_go && s1_item_q.cls.is_accept && from_ok;
	assign term_go = s1_go && s1_item_q.cls.is_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CW'(CLR_LEN - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Character map; a write in s1 is forwarded to the read issued in the same cycle.
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (pop) begin
			map_rd_q <= (map_we && (map_wa == q_item.char_code)) ? map_wd :
				map_mem[q_item.char_code];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			trans_mem[clr_cnt_q[TAW-1:0]] <= '0;
		end else if (tw) begin
			trans_mem[t_waddr] <= '{valid: 1'b1, dest: s1_item_q.to_state};
		end
		if (trd_re) begin
			trd_q <= trans_mem[t_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			acc_mem[clr_cnt_q[STW-1:0]] <= 1'b0;
		end else if (aw) begin
			acc_mem[STW'(s1_item_q.from_state)] <= s1_item_q.flag;
		end
		if (term_go) begin
			acc_rd_q <= acc_mem[STW'(run_state)];
			s2_live_q <= !run_dead && state_in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			started_q <= 1'b0;
			dead_q <= 1'b0;
			pend_q <= 1'b0;
			cur_q <= '0;
		end else begin
			if (pop) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			s2_v_q <= term_go;
			cur_q <= live_state;
			dead_q <= live_dead;
			pend_q <= 1'b0;
			if (s1_go && s1_item_q.cls.is_char) begin
				started_q <= 1'b1;
				cur_q <= run_state;
				dead_q <= !trd_re;
				pend_q <= trd_re;
			end
			if (term_go) begin
				started_q <= 1'b0;
				dead_q <= 1'b0;
				cur_q <= '0;
			end
		end
	end

	assign opush = s2_v_q;
	assign out_valid = ocnt_q != '0;
	assign opop = out_valid && out_ready;
	assign accepted = ofifo_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owptr_q <= owptr_q + 1'b1;
			end
			if (opop) begin
				orptr_q <= orptr_q + 1'b1;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_q[owptr_q] <= s2_live_q && acc_rd_q;
		end
	end

	`DFA_ASSERT_NOW(a_no_pop_in_clear, clr_q, !pop, "Item taken during the table clear.")
	`DFA_ASSERT_NOW(a_s1_one_class, s1_v_q, $onehot(s1_item_q.cls), "Item class is not one-hot.")
	`DFA_ASSERT_NEXT(a_term_gives_verdict, term_go, s2_v_q, "Terminator produced no verdict.")
	`DFA_ASSERT_NOW(a_pend_follows_read, pend_q, $past(trd_re), "Pending state without a read.")
	`DFA_ASSERT_NOW(a_verdict_has_room, s2_v_q,
		32'(ocnt_q) < tddm_pkg::OUT_DEPTH, "Verdict arrives at a full output queue.")

endmodule

@@ hdl/table_driven_dfa_matcher.sv @@
// Programmable DFA recognizer: one item per clock cycle sustained, on both channels, while
// the tables are not being cleared and the output queue has room. The next-state loop
// closes through the registered read of the transition memory, so a run advances one
// character every cycle; with nothing queued ahead of it, a terminator passes the front
// register, the item queue and the s1 and s2 registers before its verdict is offered from
// the output queue. After reset the block clears its tables, taking no transaction until
// the clear is done. Configuration writes must be made while no transaction is in flight,
// since queued items see the register values at the time they are carried out.
// Depends on tddm_pkg, tddm_front, tddm_queue and tddm_back.
module table_driven_dfa_matcher #(
	parameter int MAX_STATES = 64,
	parameter int ALPHABET_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [tddm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tddm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	input  logic [tddm_pkg::CHAR_W-1:0] char_code,
	input  logic [tddm_pkg::SYM_W-1:0] symbol_index,
	input  logic [tddm_pkg::STATE_W-1:0] from_state,
	input  logic [tddm_pkg::STATE_W-1:0] to_state,
	input  logic flag,
	output logic out_valid,
	input  logic out_ready,
	output logic accepted
);

	logic [tddm_pkg::STATE_W-1:0] start_q;
	logic [tddm_pkg::STATE_W-1:0] highest_q;
	logic busy;
	logic push;
	tddm_pkg::item_t push_item;
	logic q_ready;
	logic q_valid;
	tddm_pkg::item_t q_item;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			highest_q <= tddm_pkg::HIGHEST_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tddm_pkg::CFG_START: start_q <= cfg_data;
				tddm_pkg::CFG_HIGHEST: highest_q <= cfg_data;
			endcase
		end
	end

	tddm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.char_code(char_code),
		.symbol_index(symbol_index),
		.from_state(from_state),
		.to_state(to_state),
		.flag(flag),
		.busy(busy),
		.q_ready(q_ready),
		.push(push),
		.push_item(push_item)
	);

	tddm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.ready(q_ready),
		.valid(q_valid),
		.item(q_item),
		.pop(q_pop)
	);

	tddm_back #(
		.MAX_STATES(MAX_STATES),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.start_state(start_q),
		.highest_state(highest_q),
		.busy(busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted)
	);

endmodule
